// ----- design/gconn_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gconn_pkg
// Shared field widths and the command/status bundles that connect the
// connectivity checker's controller to its datapath.
// ----------------------------------------------------------------------------
package gconn_pkg;

  localparam int unsigned NodeFieldW  = 10;
  localparam int unsigned CountFieldW = 11;

  // Commands from the controller, one group of strobes per controller state.
  typedef struct packed {
    logic accept;    // an input word is taken this cycle
    logic start;     // begin a walk at node 0
    logic root;      // latch the degree of node 0
    logic adv;       // read the next neighbor of the top node
    logic pop;       // drop the top node, read the one below
    logic nbr;       // look up seen mark and degree of the fetched neighbor
    logic test;      // push the neighbor if it is new and in range
    logic pop_load;  // reload the top node from the stack read
    logic finish;    // register the result and clear the overflow flag
    logic sweep;     // clear one degree count and one seen mark
  } gconn_cmd_t;

  typedef struct packed {
    logic limit_zero;  // node count is zero, so node 0 is not visited
    logic pos_end;     // top node has no neighbors left
    logic top_one;     // only one node is on the stack
    logic out_busy;    // the result register still holds a word
    logic sweep_last;  // sweep is at the last node
  } gconn_status_t;

endpackage
`default_nettype wire

// ----- design/gconn_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gconn_ctrl
// Controller: sequences clearing sweeps, adjacency loading and the
// depth-first walk, and issues one command group per cycle to the datapath.
// ----------------------------------------------------------------------------
module gconn_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     last_entry_i,
  output logic                     in_ready_o,
  input  gconn_pkg::gconn_status_t status_i,
  output gconn_pkg::gconn_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_SWEEP,
    S_LOAD,
    S_DRAIN,
    S_START,
    S_ROOT,
    S_STEP,
    S_NBR,
    S_TEST,
    S_POP,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (last_entry_i) begin
            state_d = S_DRAIN;
          end
        end
      end
      // The last word still sits in the write stage during this cycle.
      S_DRAIN: state_d = S_START;
      S_START: begin
        cmd_o.start = 1'b1;
        state_d     = status_i.limit_zero ? S_DONE : S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root = 1'b1;
        state_d    = S_STEP;
      end
      S_STEP: begin
        if (status_i.pos_end) begin
          if (status_i.top_one) begin
            state_d = S_DONE;
          end else begin
            cmd_o.pop = 1'b1;
            state_d   = S_POP;
          end
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_NBR;
        end
      end
      S_NBR: begin
        cmd_o.nbr = 1'b1;
        state_d   = S_TEST;
      end
      S_TEST: begin
        cmd_o.test = 1'b1;
        state_d    = S_STEP;
      end
      S_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_STEP;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = S_SWEEP;
        end
      end
      default: state_d = S_SWEEP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_LOAD);

endmodule
`default_nettype wire

// ----- design/gconn_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gconn_dpath
// Datapath: neighbor, degree, seen-mark and stack memories, the two-stage
// load path with degree forwarding, the walk registers and the result word.
// ----------------------------------------------------------------------------
module gconn_dpath #(
  parameter int unsigned MAX_NODES  = 1024,
  parameter int unsigned MAX_DEGREE = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gconn_pkg::gconn_cmd_t                cmd_i,
  output gconn_pkg::gconn_status_t             status_o,
  input  logic                                 cfg_valid_i,
  input  logic [gconn_pkg::CountFieldW-1:0]    cfg_node_count_i,
  input  logic [gconn_pkg::NodeFieldW-1:0]     from_node_i,
  input  logic [gconn_pkg::NodeFieldW-1:0]     to_node_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [gconn_pkg::CountFieldW-1:0]    reachable_count_o,
  output logic                                 connected_o,
  output logic                                 degree_overflow_o
);

  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned AW = (MAX_NODES * MAX_DEGREE > 1) ?
                               $clog2(MAX_NODES * MAX_DEGREE) : 1;
  localparam int unsigned TW = NW + 1;
  localparam int unsigned SW = NW + 2 * DW;
  localparam int unsigned FW = gconn_pkg::NodeFieldW;
  localparam int unsigned CW = gconn_pkg::CountFieldW;

  // Memories.
  logic [FW-1:0] nbr_mem  [MAX_NODES*MAX_DEGREE];
  logic [DW-1:0] deg_mem  [MAX_NODES];
  logic          seen_mem [MAX_NODES];
  logic [SW-1:0] stk_mem  [MAX_NODES];

  logic [FW-1:0] nb_rd_q;
  logic [DW-1:0] deg_rd_q;
  logic          seen_rd_q;
  logic [SW-1:0] stk_rd_q;

  // Configuration.
  logic [CW-1:0] node_count_q;

  // Load path.
  logic          s1_v_q;
  logic [NW-1:0] s1_node_q;
  logic [FW-1:0] s1_to_q;
  logic          fwd_v_q;
  logic [NW-1:0] fwd_node_q;
  logic [DW-1:0] fwd_deg_q;
  logic          overflow_q;

  // Walk.
  logic [NW-1:0] cur_q;
  logic [DW-1:0] pos_q;
  logic [DW-1:0] degc_q;
  logic [TW-1:0] top_q;
  logic [TW-1:0] reached_q;
  logic [NW-1:0] sweep_q;

  // Result word.
  logic          out_valid_q;
  logic [CW-1:0] reach_out_q;
  logic          conn_out_q;
  logic          ovf_out_q;

  logic [31:0]   from_ext, nb_ext, limit, reached_ext;
  logic [NW-1:0] from_idx, nb_idx;
  logic          from_in;
  logic [DW-1:0] d_cur;
  logic          s1_wr;
  logic [AW-1:0] nbr_wa, nbr_ra;
  logic [NW-1:0] deg_ra, deg_wa;
  logic          deg_we;
  logic [DW-1:0] deg_wd;
  logic          seen_we, seen_wd;
  logic [NW-1:0] seen_wa;
  logic [TW-1:0] top_m1, top_m2;
  logic          push_ok;
  logic          limit_zero;

  assign from_ext = 32'(from_node_i);
  assign from_idx = from_ext[NW-1:0];
  assign from_in  = (from_ext < MAX_NODES);
  assign nb_ext   = 32'(nb_rd_q);
  assign nb_idx   = nb_ext[NW-1:0];

  assign limit      = (32'(node_count_q) < MAX_NODES) ? 32'(node_count_q) : 32'(MAX_NODES);
  assign limit_zero = (node_count_q == '0);

  // A write made in the previous cycle is not yet visible in the read data.
  assign d_cur = (fwd_v_q && (fwd_node_q == s1_node_q)) ? fwd_deg_q : deg_rd_q;
  assign s1_wr = s1_v_q && (d_cur < DW'(MAX_DEGREE));

  assign nbr_wa = AW'(32'(s1_node_q) * MAX_DEGREE + 32'(d_cur));
  assign nbr_ra = AW'(32'(cur_q) * MAX_DEGREE + 32'(pos_q));

  assign top_m1  = top_q - TW'(1);
  assign top_m2  = top_q - TW'(2);
  assign push_ok = (nb_ext < limit) && !seen_rd_q && (top_q < TW'(MAX_NODES));

  always_comb begin
    if (cmd_i.start) begin
      deg_ra = '0;
    end else if (cmd_i.nbr) begin
      deg_ra = nb_idx;
    end else begin
      deg_ra = from_idx;
    end
  end

  assign deg_we = s1_wr || cmd_i.sweep;
  assign deg_wa = cmd_i.sweep ? sweep_q : s1_node_q;
  assign deg_wd = cmd_i.sweep ? '0 : d_cur + DW'(1);

  always_comb begin
    seen_we = 1'b0;
    seen_wa = nb_idx;
    seen_wd = 1'b1;
    if (cmd_i.sweep) begin
      seen_we = 1'b1;
      seen_wa = sweep_q;
      seen_wd = 1'b0;
    end else if (cmd_i.start) begin
      seen_we = !limit_zero;
      seen_wa = '0;
    end else if (cmd_i.test) begin
      seen_we = push_ok;
    end
  end

  // The fetched neighbor is held until the next advance, through the test.
  always_ff @(posedge clk_i) begin
    if (s1_wr) begin
      nbr_mem[nbr_wa] <= s1_to_q;
    end
    if (cmd_i.adv) begin
      nb_rd_q <= nbr_mem[nbr_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    deg_rd_q <= deg_mem[deg_ra];
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    seen_rd_q <= seen_mem[nb_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.test && push_ok) begin
      stk_mem[top_m1[NW-1:0]] <= {cur_q, pos_q, degc_q};
    end
    stk_rd_q <= stk_mem[top_m2[NW-1:0]];
  end

  // Payload registers of the load and walk paths.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1_node_q <= from_idx;
      s1_to_q   <= to_node_i;
    end
    fwd_node_q <= s1_node_q;
    fwd_deg_q  <= d_cur + DW'(1);
    if (cmd_i.start) begin
      cur_q <= '0;
      pos_q <= '0;
    end else if (cmd_i.root) begin
      degc_q <= deg_rd_q;
    end else if (cmd_i.adv) begin
      pos_q <= pos_q + DW'(1);
    end else if (cmd_i.pop_load) begin
      {cur_q, pos_q, degc_q} <= stk_rd_q;
    end else if (cmd_i.test && push_ok) begin
      cur_q  <= nb_idx;
      pos_q  <= '0;
      degc_q <= deg_rd_q;
    end
    if (cmd_i.finish) begin
      reach_out_q <= reached_ext[CW-1:0];
      conn_out_q  <= (reached_ext == 32'(node_count_q));
      ovf_out_q   <= overflow_q;
    end
  end

  assign reached_ext = 32'(reached_q);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CW'(1);
      s1_v_q       <= 1'b0;
      fwd_v_q      <= 1'b0;
      overflow_q   <= 1'b0;
      top_q        <= '0;
      reached_q    <= '0;
      sweep_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        node_count_q <= cfg_node_count_i;
      end
      s1_v_q  <= cmd_i.accept && from_in;
      fwd_v_q <= s1_wr;
      if (s1_v_q && !s1_wr) begin
        overflow_q <= 1'b1;
      end else if (cmd_i.finish) begin
        overflow_q <= 1'b0;
      end
      if (cmd_i.start) begin
        top_q     <= limit_zero ? '0 : TW'(1);
        reached_q <= limit_zero ? '0 : TW'(1);
      end else if (cmd_i.pop) begin
        top_q <= top_m1;
      end else if (cmd_i.test && push_ok) begin
        top_q     <= top_q + TW'(1);
        reached_q <= reached_q + TW'(1);
      end
      if (cmd_i.sweep) begin
        sweep_q <= status_o.sweep_last ? '0 : sweep_q + NW'(1);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.limit_zero = limit_zero;
  assign status_o.pos_end    = (pos_q >= degc_q);
  assign status_o.top_one    = (top_q == TW'(1));
  assign status_o.out_busy   = out_valid_q;
  assign status_o.sweep_last = (sweep_q == NW'(MAX_NODES - 1));

  assign out_valid_o       = out_valid_q;
  assign reachable_count_o = reach_out_q;
  assign connected_o       = conn_out_q;
  assign degree_overflow_o = ovf_out_q;

endmodule
`default_nettype wire

// ----- design/graph_connectivity_check_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// graph_connectivity_check_core
// Loads a directed graph as adjacency words and checks depth-first whether
// every node is reachable from node 0.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid_i/in_ready_o) carries from_node_i, to_node_i
//   and last_entry_i, one adjacency word per cycle while in_ready_o is high.
//   Words for a full list are dropped and flagged in degree_overflow_o.
// - A word with last_entry_i set starts the check; in_ready_o stays low until
//   the walk and the following clearing sweep are done.
// - Each neighbor visited passes through the STEP, NBR and TEST states, and
//   each node left through STEP and POP; each step waits on one registered
//   memory read. A result word then appears on out_valid_o.
// - After each result, and after reset, a sweep clears degree counts and seen
//   marks, one node per cycle, with in_ready_o low.
// - The result sits in an output register; a stalled receiver does not stop
//   the sweep or the next graph's loading, only the next result.
// - cfg_node_count_i is written whenever cfg_valid_i is high, and must only
//   change while the block is idle. Its reset value is 1.
// ----------------------------------------------------------------------------
module graph_connectivity_check_core #(
  parameter int unsigned MAX_NODES  = 1024,
  parameter int unsigned MAX_DEGREE = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gconn_pkg::CountFieldW-1:0] cfg_node_count_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gconn_pkg::NodeFieldW-1:0]  from_node_i,
  input  logic [gconn_pkg::NodeFieldW-1:0]  to_node_i,
  input  logic                              last_entry_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gconn_pkg::CountFieldW-1:0] reachable_count_o,
  output logic                              connected_o,
  output logic                              degree_overflow_o
);

  gconn_pkg::gconn_cmd_t    cmd;
  gconn_pkg::gconn_status_t status;

  assign cfg_ready_o = 1'b1;

  gconn_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_entry_i (last_entry_i),
    .in_ready_o   (in_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  gconn_dpath #(
    .MAX_NODES  (MAX_NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_node_count_i  (cfg_node_count_i),
    .from_node_i       (from_node_i),
    .to_node_i         (to_node_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .reachable_count_o (reachable_count_o),
    .connected_o       (connected_o),
    .degree_overflow_o (degree_overflow_o)
  );

endmodule
`default_nettype wire

// ----- design/gconn_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gconn_checker
// Port-level checks for the connectivity checker, bound to the top level.
// ----------------------------------------------------------------------------
module gconn_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              last_entry_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [gconn_pkg::CountFieldW-1:0] reachable_count_o,
  input logic                              connected_o,
  input logic                              degree_overflow_o
);

  // A held result word must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reachable_count_o)
      && $stable(connected_o) && $stable(degree_overflow_o))
    else $error("result word changed while stalled");

  // The last word of a graph closes the input until the check is over.
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_entry_i |=> !in_ready_o)
    else $error("input still open after last word");

  // A new result is only produced while loading is stopped.
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("result produced while loading");

endmodule

bind graph_connectivity_check_core gconn_checker u_gconn_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .last_entry_i      (last_entry_i),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .reachable_count_o (reachable_count_o),
  .connected_o       (connected_o),
  .degree_overflow_o (degree_overflow_o)
);
`default_nettype wire

// ----- tb/graph_connectivity_check_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// graph_connectivity_check_core_test
// Streams directed graphs into the connectivity checker under several node
// count settings and handshake idling patterns. A local depth-first walk
// over a shadow copy of the neighbor lists predicts each result word.
// ----------------------------------------------------------------------------
module graph_connectivity_check_core_test;

  localparam int unsigned MAX_NODES     = 1024;
  localparam int unsigned MAX_DEGREE    = 16;
  localparam int unsigned CLK_PERIOD    = 4;
  localparam int unsigned SETTLE_CYCLES = MAX_NODES + 64;
  localparam int unsigned CYCLE_LIMIT   = 5000000;
  localparam int unsigned RAND_WORDS    = 400;
  localparam int unsigned NodeW         = gconn_pkg::NodeFieldW;
  localparam int unsigned CountW        = gconn_pkg::CountFieldW;

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;
    logic             is_last;
  } adj_word_t;

  typedef struct packed {
    logic [CountW-1:0] reached;
    logic              connected;
    logic              overflow;
  } graph_result_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CountW-1:0] cfg_node_count_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [NodeW-1:0]  from_node_i;
  logic [NodeW-1:0]  to_node_i;
  logic              last_entry_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CountW-1:0] reachable_count_o;
  logic              connected_o;
  logic              degree_overflow_o;

  graph_connectivity_check_core #(
    .MAX_NODES (MAX_NODES),
    .MAX_DEGREE(MAX_DEGREE)
  ) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_node_count_i (cfg_node_count_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .from_node_i      (from_node_i),
    .to_node_i        (to_node_i),
    .last_entry_i     (last_entry_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .reachable_count_o(reachable_count_o),
    .connected_o      (connected_o),
    .degree_overflow_o(degree_overflow_o)
  );

  // Shadow copy of the block's graph state.
  logic [NodeW-1:0]  nbr_mem [MAX_NODES*MAX_DEGREE];
  int unsigned       deg_cnt [MAX_NODES];
  logic              seen [MAX_NODES];
  int unsigned       stk_node [MAX_NODES];
  int unsigned       stk_pos [MAX_NODES];
  logic              ovf_seen;
  logic [CountW-1:0] node_setting;

  adj_word_t     word_q[$];
  graph_result_t result_q[$];
  graph_result_t head;
  adj_word_t     next_word;
  int unsigned   words_left;
  int unsigned   cfg_writes;
  int unsigned   errors;
  int unsigned   cycles;
  logic          in_took;
  idle_mode_e    idle_mode;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned count_reachable();
    int unsigned lim, reached, top, cur, pos, nb;
    lim = (node_setting < MAX_NODES) ? 32'(node_setting) : MAX_NODES;
    for (int i = 0; i < MAX_NODES; i++) seen[i] = 1'b0;
    if (lim == 0) return 0;
    seen[0] = 1'b1;
    reached = 1;
    stk_node[0] = 0;
    stk_pos[0] = 0;
    top = 1;
    while (top > 0) begin
      cur = stk_node[top-1];
      pos = stk_pos[top-1];
      if (pos >= deg_cnt[cur]) begin
        top--;
      end else begin
        stk_pos[top-1] = pos + 1;
        nb = 32'(nbr_mem[cur*MAX_DEGREE + pos]);
        if (nb < lim && !seen[nb] && top < MAX_NODES) begin
          seen[nb] = 1'b1;
          reached++;
          stk_node[top] = nb;
          stk_pos[top] = 0;
          top++;
        end
      end
    end
    return reached;
  endfunction

  // Appends one adjacency word; the final word of a graph yields a result.
  function automatic void absorb_word(adj_word_t w);
    graph_result_t r;
    int unsigned   src, reached;
    src = 32'(w.src);
    if (deg_cnt[src] < MAX_DEGREE) begin
      nbr_mem[src*MAX_DEGREE + deg_cnt[src]] = w.dst;
      deg_cnt[src]++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (w.is_last) begin
      reached = count_reachable();
      r.reached = reached[CountW-1:0];
      r.connected = (reached == 32'(node_setting));
      r.overflow = ovf_seen;
      result_q = {result_q, r};
      for (int i = 0; i < MAX_NODES; i++) deg_cnt[i] = 0;
      ovf_seen = 1'b0;
    end
  endfunction

  task automatic flag_error(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic bit skip_cycle(bit sender);
    int unsigned pct;
    case (idle_mode)
      IDLE_SEND: pct = sender ? 61 : 0;
      IDLE_RECV: pct = sender ? 0 : 61;
      IDLE_BOTH: pct = 24;
      default:   pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  // Driver: a word stays on the bus until taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (word_q.size() != 0 && !skip_cycle(1'b1)) begin
        next_word = word_q.pop_front();
        in_valid_i <= 1'b1;
        from_node_i <= next_word.src;
        to_node_i <= next_word.dst;
        last_entry_i <= next_word.is_last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= !skip_cycle(1'b0);
  end

  // Monitor: tracks accepted words and configuration, checks result words.
  always @(posedge clk_i) begin
    in_took <= in_valid_i && in_ready_o;
    if (cfg_valid_i && cfg_ready_o) begin
      node_setting = cfg_node_count_i;
      cfg_writes++;
    end
    if (in_valid_i && in_ready_o) begin
      absorb_word('{src: from_node_i, dst: to_node_i, is_last: last_entry_i});
      words_left--;
    end
    if (out_valid_o && out_ready_i) begin
      if (result_q.size() == 0) begin
        flag_error($sformatf("unexpected result word, count %0d", reachable_count_o));
      end else begin
        head = result_q.pop_front();
        if (reachable_count_o !== head.reached)
          flag_error($sformatf("reachable_count %0d, expected %0d",
                               reachable_count_o, head.reached));
        if (connected_o !== head.connected)
          flag_error($sformatf("connected %0b, expected %0b", connected_o, head.connected));
        if (degree_overflow_o !== head.overflow)
          flag_error($sformatf("degree_overflow %0b, expected %0b",
                               degree_overflow_o, head.overflow));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_word(int unsigned src, int unsigned dst, bit is_last);
    adj_word_t w;
    w.src = src[NodeW-1:0];
    w.dst = dst[NodeW-1:0];
    w.is_last = is_last;
    word_q = {word_q, w};
    words_left++;
  endtask

  task automatic wait_for_drain();
    while (words_left != 0 || result_q.size() != 0) @(negedge clk_i);
  endtask

  // The sweep after the last result still runs, so let it finish first.
  task automatic program_node_count(int unsigned value);
    int unsigned prev;
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    prev = cfg_writes;
    cfg_node_count_i <= value[CountW-1:0];
    cfg_valid_i <= 1'b1;
    while (cfg_writes == prev) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Builds one graph whose nodes mostly lie inside the walk's range.
  task automatic queue_graph(int unsigned setting, output int unsigned n_words);
    adj_word_t   edges[$];
    adj_word_t   w;
    int unsigned lim, span, kind, cnt, j, hub;
    lim = (setting < MAX_NODES) ? setting : MAX_NODES;
    span = (lim == 0) ? 1 : ((lim > 24) ? $urandom_range(2, 24) : lim);
    kind = $urandom_range(0, 9);
    w.is_last = 1'b0;
    if (kind < 6) begin
      // A spanning tree over the first span nodes, plus a few extra edges.
      for (int i = 1; i < span; i++) begin
        w.src = NodeW'($urandom_range(0, i - 1));
        w.dst = NodeW'(i);
        edges = {edges, w};
      end
      cnt = $urandom_range(0, 6);
      for (int i = 0; i < cnt; i++) begin
        w.src = NodeW'($urandom_range(0, span - 1));
        w.dst = NodeW'(($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_NODES - 1)
                                                   : $urandom_range(0, span - 1));
        edges = {edges, w};
      end
    end else if (kind < 8) begin
      cnt = $urandom_range(1, 20);
      for (int i = 0; i < cnt; i++) begin
        w.src = NodeW'($urandom_range(0, span - 1));
        w.dst = NodeW'($urandom_range(0, span - 1));
        edges = {edges, w};
      end
    end else if (kind == 8) begin
      cnt = $urandom_range(1, 12);
      for (int i = 0; i < cnt; i++) begin
        w.src = NodeW'($urandom_range(0, MAX_NODES - 1));
        w.dst = NodeW'($urandom_range(0, MAX_NODES - 1));
        edges = {edges, w};
      end
    end else begin
      // Enough edges on one node to run past its list.
      hub = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, span - 1);
      cnt = $urandom_range(MAX_DEGREE + 1, MAX_DEGREE + 4);
      for (int i = 0; i < cnt; i++) begin
        w.src = NodeW'(hub);
        w.dst = NodeW'($urandom_range(0, span - 1));
        edges = {edges, w};
      end
    end
    if (edges.size() == 0) begin
      w.src = '0;
      w.dst = '0;
      edges = {edges, w};
    end
    for (int i = edges.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      w = edges[i];
      edges[i] = edges[j];
      edges[j] = w;
    end
    edges[edges.size()-1].is_last = 1'b1;
    foreach (edges[i]) queue_word(32'(edges[i].src), 32'(edges[i].dst), edges[i].is_last);
    n_words = edges.size();
  endtask

  initial begin
    int unsigned node_plan [12];
    int unsigned phase, rand_words, phase_words, n;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_node_count_i = '0;
    in_valid_i = 1'b0;
    from_node_i = '0;
    to_node_i = '0;
    last_entry_i = 1'b0;
    out_ready_i = 1'b0;
    in_took = 1'b0;
    words_left = 0;
    cfg_writes = 0;
    errors = 0;
    cycles = 0;
    idle_mode = IDLE_NONE;
    ovf_seen = 1'b0;
    node_setting = 1;
    for (int i = 0; i < MAX_NODES; i++) deg_cnt[i] = 0;
    node_plan = '{5, 2047, 24, 0, 1024, 1, 16, 1025, 2, 40, 7, 12};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset node count of one: a self loop, then an out-of-range neighbor.
    queue_word(0, 0, 1'b1);
    queue_word(1023, 1023, 1'b0);
    queue_word(0, 1023, 1'b1);

    // Full node range, with a repeated edge and the top node reached.
    program_node_count(1024);
    queue_word(0, 1, 1'b0);
    queue_word(1, 1023, 1'b0);
    queue_word(1023, 0, 1'b0);
    queue_word(0, 1, 1'b0);
    queue_word(1, 2, 1'b1);

    // Zero node count: nothing is visited, yet the graph counts as connected.
    program_node_count(0);
    queue_word(0, 5, 1'b1);

    // A full neighbor list on node 0; the last word is dropped.
    program_node_count(2);
    for (int i = 0; i < MAX_DEGREE; i++) queue_word(0, 0, 1'b0);
    queue_word(0, 1, 1'b1);

    phase = 0;
    rand_words = 0;
    while (rand_words < RAND_WORDS) begin
      program_node_count(node_plan[phase % 12]);
      idle_mode = idle_mode_e'(phase % 4);
      phase_words = 0;
      while (phase_words < 40) begin
        // Now and then hold back until every pending result is out.
        if ($urandom_range(0, 7) == 0) wait_for_drain();
        queue_graph(node_plan[phase % 12], n);
        phase_words += n;
      end
      rand_words += phase_words;
      phase++;
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- graph_connectivity_check_core.f -----
design/gconn_pkg.sv
design/gconn_ctrl.sv
design/gconn_dpath.sv
design/graph_connectivity_check_core.sv
design/gconn_checker.sv
tb/graph_connectivity_check_core_test.sv
